[rtl/core/assert_macros.svh]
// Assertion macros shared by the debounced key event queue modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DKEQ_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DKEQ_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define DKEQ_ASSERT(label, clk, rst, prop, msg)
`define DKEQ_NEVER(label, clk, rst, expr, msg)
`endif
`endif

[rtl/core/dkeq_pkg.sv]
// Package with the constants and types of the debounced key event queue.
package dkeq_pkg;

  localparam int NUM_KEYS    = 9;
  localparam int QUEUE_DEPTH = 16;
  localparam int KEY_W       = 4;
  localparam int KEY_IDX_W   = $clog2(NUM_KEYS);
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int EVT_W       = KEY_W + 1;
  localparam int TIME_W      = 32;
  localparam int CMD_W       = 2;
  localparam int DROP_W      = 4;
  localparam int FILL_W      = 4;
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 24;

  localparam logic [TIME_W-1:0] DEBOUNCE_RESET = TIME_W'(15000);

  localparam logic [CMD_W-1:0] CMD_SCAN  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_POP,
    ST_CLEAR,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_item;
    logic scan_step;
    logic pop_read;
    logic clear_queue;
    logic load_result;
  } dp_cmd_t;

  typedef struct packed {
    logic last_key;
  } dp_status_t;

endpackage

[rtl/core/dkeq_datapath.sv]
// Datapath: key debounce state, event ring buffer and result register.
`include "assert_macros.svh"

module dkeq_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [dkeq_pkg::TIME_W-1:0]         cfg_wr_data,
  input  logic [dkeq_pkg::NUM_KEYS-1:0]       in_pins,
  input  logic [dkeq_pkg::TIME_W-1:0]         in_time,
  input  dkeq_pkg::dp_cmd_t                   cmd,
  output dkeq_pkg::dp_status_t                status,
  output logic                                res_pop_valid,
  output logic [dkeq_pkg::KEY_W-1:0]          res_pop_key,
  output logic                                res_pop_pressed,
  output logic [dkeq_pkg::DROP_W-1:0]         res_dropped,
  output logic [dkeq_pkg::FILL_W-1:0]         res_fill,
  output logic [dkeq_pkg::NUM_KEYS-1:0]       res_stable
);

  logic [dkeq_pkg::TIME_W-1:0]    debounce_time;
  logic [dkeq_pkg::NUM_KEYS-1:0]  pins;
  logic [dkeq_pkg::TIME_W-1:0]    now;
  logic [dkeq_pkg::KEY_IDX_W-1:0] key_idx;
  logic [dkeq_pkg::NUM_KEYS-1:0]  stable_pressed;
  logic [dkeq_pkg::NUM_KEYS-1:0]  last_raw;
  logic [dkeq_pkg::TIME_W-1:0]    change_time [dkeq_pkg::NUM_KEYS];
  logic [dkeq_pkg::PTR_W-1:0]     write_ptr;
  logic [dkeq_pkg::PTR_W-1:0]     read_ptr;
  logic [dkeq_pkg::DROP_W-1:0]    dropped;
  logic                           pop_hit;
  logic [dkeq_pkg::EVT_W-1:0]     evt_mem [dkeq_pkg::QUEUE_DEPTH];
  logic [dkeq_pkg::EVT_W-1:0]     rd_evt;

  logic                           raw;
  logic                           changed;
  logic [dkeq_pkg::TIME_W-1:0]    elapsed;
  logic                           settled;
  logic                           fire;
  logic                           full;
  logic                           empty;

  assign raw     = ~pins[key_idx];
  assign changed = raw != last_raw[key_idx];
  assign elapsed = now - change_time[key_idx];
  assign settled = changed ? (debounce_time == '0) : (elapsed >= debounce_time);
  assign fire    = (raw != stable_pressed[key_idx]) && settled;
  assign full    = (write_ptr + 1'b1) == read_ptr;
  assign empty   = write_ptr == read_ptr;

  assign status.last_key = key_idx == dkeq_pkg::KEY_IDX_W'(dkeq_pkg::NUM_KEYS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time <= dkeq_pkg::DEBOUNCE_RESET;
    end else if (cfg_wr_en) begin
      debounce_time <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      pins <= in_pins;
      now  <= in_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_idx        <= '0;
      dropped        <= '0;
      pop_hit        <= 1'b0;
      stable_pressed <= '0;
      last_raw       <= '0;
      write_ptr      <= '0;
      read_ptr       <= '0;
      for (int i = 0; i < dkeq_pkg::NUM_KEYS; i++) begin
        change_time[i] <= '0;
      end
    end else begin
      if (cmd.load_item) begin
        key_idx <= '0;
        dropped <= '0;
        pop_hit <= 1'b0;
      end
      if (cmd.scan_step) begin
        key_idx <= key_idx + 1'b1;
        if (changed) begin
          last_raw[key_idx]    <= raw;
          change_time[key_idx] <= now;
        end
        if (fire) begin
          stable_pressed[key_idx] <= raw;
          if (full) begin
            dropped <= dropped + 1'b1;
          end else begin
            write_ptr <= write_ptr + 1'b1;
          end
        end
      end
      if (cmd.pop_read && !empty) begin
        pop_hit  <= 1'b1;
        read_ptr <= read_ptr + 1'b1;
      end
      if (cmd.clear_queue) begin
        write_ptr <= '0;
        read_ptr  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && fire && !full) begin
      evt_mem[write_ptr] <= {raw, dkeq_pkg::KEY_W'(key_idx)};
    end
    if (cmd.pop_read) begin
      rd_evt <= evt_mem[read_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      res_pop_valid   <= pop_hit;
      res_pop_key     <= pop_hit ? rd_evt[dkeq_pkg::KEY_W-1:0] : '0;
      res_pop_pressed <= pop_hit & rd_evt[dkeq_pkg::KEY_W];
      res_dropped     <= dropped;
      res_fill        <= dkeq_pkg::FILL_W'(write_ptr - read_ptr);
      res_stable      <= stable_pressed;
    end
  end

  `DKEQ_NEVER(a_key_idx_range, clk, rst,
              cmd.scan_step && (key_idx > dkeq_pkg::KEY_IDX_W'(dkeq_pkg::NUM_KEYS - 1)),
              "key index beyond last key")
  `DKEQ_ASSERT(a_pop_empty_holds, clk, rst,
               (cmd.pop_read && empty && !cmd.clear_queue) |=> $stable(read_ptr),
               "pop of an empty queue moved the read pointer")

endmodule

[rtl/core/dkeq_ctrl.sv]
// Controller: sequences scan, pop and clear work and owns the result handshake.
`include "assert_macros.svh"

module dkeq_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [dkeq_pkg::CMD_W-1:0]       s_cmd,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output dkeq_pkg::dp_cmd_t                cmd,
  input  dkeq_pkg::dp_status_t             status
);

  dkeq_pkg::state_t state;
  dkeq_pkg::state_t state_next;
  logic             out_valid;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dkeq_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      dkeq_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_item = 1'b1;
          unique case (s_cmd)
            dkeq_pkg::CMD_SCAN:  state_next = dkeq_pkg::ST_SCAN;
            dkeq_pkg::CMD_POP:   state_next = dkeq_pkg::ST_POP;
            dkeq_pkg::CMD_CLEAR: state_next = dkeq_pkg::ST_CLEAR;
            default:             state_next = dkeq_pkg::ST_FINISH;
          endcase
        end
      end
      dkeq_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.last_key) begin
          state_next = dkeq_pkg::ST_FINISH;
        end
      end
      dkeq_pkg::ST_POP: begin
        cmd.pop_read = 1'b1;
        state_next   = dkeq_pkg::ST_FINISH;
      end
      dkeq_pkg::ST_CLEAR: begin
        cmd.clear_queue = 1'b1;
        state_next      = dkeq_pkg::ST_FINISH;
      end
      dkeq_pkg::ST_FINISH: begin
        if (!out_valid || m_tready) begin
          cmd.load_result = 1'b1;
          state_next      = dkeq_pkg::ST_IDLE;
        end
      end
      default: state_next = dkeq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_result) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  assign m_tvalid = out_valid;

  `DKEQ_NEVER(a_no_overwrite, clk, rst, cmd.load_result && out_valid && !m_tready,
              "result overwritten before it was taken")
  `DKEQ_ASSERT(a_accept_leaves_idle, clk, rst,
               (s_tvalid && s_tready) |=> (state != dkeq_pkg::ST_IDLE),
               "accepted beat did not start work")

endmodule

[rtl/core/debounced_key_event_queue.sv]
// Top level of the debounced key event queue.
// Each input beat is a scan, a pop or a clear command. A scan walks the nine keys one per
// cycle between acceptance and the result load; a pop or a clear runs its own work state
// before the result load, the pop waiting on the registered read of the event memory.
// A new beat is accepted as soon as the controller is idle, even while the previous result
// waits on the output register. The debounce time resets to 15000 us; the user must write
// it through cfg_wr_en and cfg_wr_data only while the block is idle, which is not enforced.
module debounced_key_event_queue (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [dkeq_pkg::TIME_W-1:0]         cfg_wr_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // pin_levels [8:0], time_now_us [40:9], zero fill above.
  input  logic [dkeq_pkg::IN_DATA_W-1:0]      s_tdata,
  // cmd [1:0].
  input  logic [dkeq_pkg::CMD_W-1:0]          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // pop_key [3:0], pop_pressed [4], dropped_events [8:5], queue_fill [12:9],
  // stable_keys [21:13], zero fill above.
  output logic [dkeq_pkg::OUT_DATA_W-1:0]     m_tdata,
  // pop_valid [0].
  output logic                                m_tuser
);

  dkeq_pkg::dp_cmd_t                dp_cmd;
  dkeq_pkg::dp_status_t             dp_status;
  logic [dkeq_pkg::KEY_W-1:0]       res_pop_key;
  logic                             res_pop_pressed;
  logic [dkeq_pkg::DROP_W-1:0]      res_dropped;
  logic [dkeq_pkg::FILL_W-1:0]      res_fill;
  logic [dkeq_pkg::NUM_KEYS-1:0]    res_stable;

  dkeq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_cmd    (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (dp_cmd),
    .status   (dp_status)
  );

  dkeq_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_pins         (s_tdata[dkeq_pkg::NUM_KEYS-1:0]),
    .in_time         (s_tdata[dkeq_pkg::NUM_KEYS +: dkeq_pkg::TIME_W]),
    .cmd             (dp_cmd),
    .status          (dp_status),
    .res_pop_valid   (m_tuser),
    .res_pop_key     (res_pop_key),
    .res_pop_pressed (res_pop_pressed),
    .res_dropped     (res_dropped),
    .res_fill        (res_fill),
    .res_stable      (res_stable)
  );

  assign m_tdata = {2'b00, res_stable, res_fill, res_dropped, res_pop_pressed, res_pop_key};

endmodule
